>>> rtl/pgng_pkg.sv
package pgng_pkg;

    localparam int UNIFORM_BITS_DEF = 24;
    localparam int GAIN_W           = 16;
    localparam int SAMPLE_W         = 23;
    localparam int STEPS            = 32;

    localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

    localparam logic [33:0] SAMPLE_MAX     = 34'd4194303;
    localparam logic [33:0] SAMPLE_MIN_MAG = 34'd4194304;

    // one digit of a bitwise integer square root
    typedef struct packed {
        logic [63:0] n;
        logic [63:0] r;
    } root_t;

    function automatic root_t root_step(root_t x, logic [63:0] b);
        root_t       y;
        logic [63:0] t;
        t = x.r + b;
        if (x.n >= t) begin
            y.n = x.n - t;
            y.r = (x.r >> 1) + b;
        end else begin
            y.n = x.n;
            y.r = x.r >> 1;
        end
        return y;
    endfunction

endpackage

>>> rtl/polar_gaussian_noise_generator_core.sv
// polar gaussian noise generator core
// each request on the s_ channel is one trial of the polar box-muller method:
// two uniform words a and b are mapped to u = 2a/2^N - 1 and v = 2b/2^N - 1.
// a trial with s = u*u + v*v outside (0,1) is dropped and gives no result;
// an accepted trial gives two requests on the m_ channel, u*m then v*m with
// m_last high, where m = sqrt(-2 ln s / s), scaled by noise_gain (q1.15),
// truncated and saturated to signed q4.19 (plus or minus eight).
// cfg_* writes noise_gain and is always ready; the user must write it only
// while idle, the block itself does not enforce this.
// throughput: one trial enters per cycle while s_ready is high; each accepted
// trial occupies the result port for two samples, first and last.
// the 32-step log2 squaring chain, the two 32-step root chains and the two
// 32-step divide chains are fully pipelined, one step per register stage.
// reset (aresetn low, synchronous) clears all valid bits and the gain.
// the whole pipeline holds, and s_ready drops, when the output pair register
// cannot take the next pair and one is waiting; nothing is lost or repeated
module polar_gaussian_noise_generator_core #(
    parameter int UNIFORM_BITS = pgng_pkg::UNIFORM_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pgng_pkg::GAIN_W-1:0]          cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [UNIFORM_BITS-1:0]              s_uniform_a,
    input  logic [UNIFORM_BITS-1:0]              s_uniform_b,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [pgng_pkg::SAMPLE_W-1:0] m_noise_sample,
    output logic                                 m_last
);

    localparam int N  = UNIFORM_BITS;
    localparam int SW = 2 * N;
    localparam int ST = pgng_pkg::STEPS;
    localparam logic [N-1:0] HALF = {1'b1, {(N-1){1'b0}}};

    // global advance: every stage moves together
    logic adv;

    // gain register
    logic [pgng_pkg::GAIN_W-1:0] gain_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= '0;
        end else if (cfg_valid) begin
            gain_reg <= cfg_data;
        end
    end

    // stage 1: offsets from one half, sign kept apart
    logic         v1_reg, na1_reg, nb1_reg;
    logic [N-1:0] da1_reg, db1_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            na1_reg <= !s_uniform_a[N-1];
            nb1_reg <= !s_uniform_b[N-1];
            da1_reg <= s_uniform_a[N-1] ? {1'b0, s_uniform_a[N-2:0]} : HALF - s_uniform_a;
            db1_reg <= s_uniform_b[N-1] ? {1'b0, s_uniform_b[N-2:0]} : HALF - s_uniform_b;
        end
    end

    // stage 2: squares
    logic          v2_reg, na2_reg, nb2_reg;
    logic [N-1:0]  da2_reg, db2_reg;
    logic [SW-1:0] sqa2_reg, sqb2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            na2_reg  <= na1_reg;
            nb2_reg  <= nb1_reg;
            da2_reg  <= da1_reg;
            db2_reg  <= db1_reg;
            sqa2_reg <= SW'(da1_reg) * SW'(da1_reg);
            sqb2_reg <= SW'(db1_reg) * SW'(db1_reg);
        end
    end

    // stage 3: sum of squares and rejection
    logic [SW-1:0] s3_next;
    logic          v3_reg, na3_reg, nb3_reg;
    logic [N-1:0]  da3_reg, db3_reg;
    logic [SW-1:0] s3_reg;
    assign s3_next = sqa2_reg + sqb2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            // reject s == 0 and s >= 1
            v3_reg <= v2_reg && (s3_next != '0) && (s3_next[SW-1:SW-2] == 2'b00);
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            na3_reg <= na2_reg;
            nb3_reg <= nb2_reg;
            da3_reg <= da2_reg;
            db3_reg <= db2_reg;
            s3_reg  <= s3_next;
        end
    end

    // stage 4: leading one position
    logic [5:0]    e4_next;
    logic          v4_reg, na4_reg, nb4_reg;
    logic [N-1:0]  da4_reg, db4_reg;
    logic [SW-1:0] s4_reg;
    logic [5:0]    e4_reg;
    always_comb begin
        e4_next = '0;
        for (int i = 0; i < SW; i++) begin
            if (s3_reg[i]) begin
                e4_next = 6'(i);
            end
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= v3_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            na4_reg <= na3_reg;
            nb4_reg <= nb3_reg;
            da4_reg <= da3_reg;
            db4_reg <= db3_reg;
            s4_reg  <= s3_reg;
            e4_reg  <= e4_next;
        end
    end

    // stage 5 feeds phase a: normalized mantissa, root operand, exponents
    logic [63:0] s64;
    logic [31:0] f5_next;
    logic [5:0]  j5_next;
    logic [6:0]  te5_next;
    assign s64      = 64'(s4_reg);
    assign f5_next  = (e4_reg >= 6'd31) ? 32'(s64 >> (e4_reg - 6'd31))
                                        : 32'(s64 << (6'd31 - e4_reg));
    assign j5_next  = 6'((7'd61 - 7'(e4_reg)) >> 1);
    assign te5_next = 7'(SW - 2) - 7'(e4_reg);

    // phase a: log2 fraction by squaring, and root of s scaled by 4^j
    logic                 va_reg   [0:ST];
    logic                 naa_reg  [0:ST];
    logic                 nba_reg  [0:ST];
    logic [N-1:0]         daa_reg  [0:ST];
    logic [N-1:0]         dba_reg  [0:ST];
    logic [5:0]           ja_reg   [0:ST];
    logic [6:0]           tea_reg  [0:ST];
    logic [31:0]          fa_reg   [0:ST];
    logic [31:0]          fraca_reg[0:ST];
    pgng_pkg::root_t      ra_reg   [0:ST];

    for (genvar k = 0; k <= ST; k++) begin : g_phase_a
        logic            v_next, na_next, nb_next;
        logic [N-1:0]    da_next, db_next;
        logic [5:0]      j_next;
        logic [6:0]      te_next;
        logic [31:0]     f_next, frac_next;
        pgng_pkg::root_t r_next;
        if (k == 0) begin : g_head
            always_comb begin
                v_next    = v4_reg;
                na_next   = na4_reg;
                nb_next   = nb4_reg;
                da_next   = da4_reg;
                db_next   = db4_reg;
                j_next    = j5_next;
                te_next   = te5_next;
                f_next    = f5_next;
                frac_next = '0;
                r_next.n  = s64 << {j5_next, 1'b0};
                r_next.r  = '0;
            end
        end else begin : g_step
            logic [63:0] p;
            logic [32:0] p31;
            always_comb begin
                p         = 64'(fa_reg[k-1]) * 64'(fa_reg[k-1]);
                p31       = p[63:31];
                v_next    = va_reg[k-1];
                na_next   = naa_reg[k-1];
                nb_next   = nba_reg[k-1];
                da_next   = daa_reg[k-1];
                db_next   = dba_reg[k-1];
                j_next    = ja_reg[k-1];
                te_next   = tea_reg[k-1];
                f_next    = p31[32] ? p31[32:1] : p31[31:0];
                frac_next = {fraca_reg[k-1][30:0], p31[32]};
                r_next    = pgng_pkg::root_step(ra_reg[k-1],
                                                64'(1) << (62 - 2 * (k - 1)));
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                va_reg[k] <= 1'b0;
            end else if (adv) begin
                va_reg[k] <= v_next;
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                naa_reg[k]   <= na_next;
                nba_reg[k]   <= nb_next;
                daa_reg[k]   <= da_next;
                dba_reg[k]   <= db_next;
                ja_reg[k]    <= j_next;
                tea_reg[k]   <= te_next;
                fa_reg[k]    <= f_next;
                fraca_reg[k] <= frac_next;
                ra_reg[k]    <= r_next;
            end
        end
    end

    // phase b, stage 1: -log2 s in q.32 times ln 2
    logic [38:0] tb_next;
    logic        vb_reg, nab_reg, nbb_reg;
    logic [N-1:0] dab_reg, dbb_reg;
    logic [5:0]  jb_reg;
    logic [31:0] qb_reg;
    logic [38:0] hib_reg;
    logic [63:0] lob_reg;
    assign tb_next = {tea_reg[ST], 32'b0} - {7'b0, fraca_reg[ST]};
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (adv) begin
            vb_reg <= va_reg[ST];
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            nab_reg <= naa_reg[ST];
            nbb_reg <= nba_reg[ST];
            dab_reg <= daa_reg[ST];
            dbb_reg <= dba_reg[ST];
            jb_reg  <= ja_reg[ST];
            qb_reg  <= ra_reg[ST].r[31:0];
            hib_reg <= 39'(tb_next[38:32]) * 39'(pgng_pkg::LN2_Q32);
            lob_reg <= 64'(tb_next[31:0]) * 64'(pgng_pkg::LN2_Q32);
        end
    end

    // phase b, stage 2 feeds phase c: -2 ln s in q.40, dividends
    logic [63:0] wc_next, numa_next, numb_next;
    assign wc_next   = ((64'(hib_reg) << 8) + (lob_reg >> 24)) << 1;
    assign numa_next = (64'(dab_reg) << jb_reg) << 30;
    assign numb_next = (64'(dbb_reg) << jb_reg) << 30;

    // phase c: root of w and the two ratio divisions, one bit per stage
    logic            vc_reg   [0:ST];
    logic            nac_reg  [0:ST];
    logic            nbc_reg  [0:ST];
    logic [31:0]     qc_reg   [0:ST];
    logic [31:0]     rema_reg [0:ST];
    logic [31:0]     remb_reg [0:ST];
    logic [31:0]     loa_reg  [0:ST];
    logic [31:0]     lob2_reg [0:ST];
    logic [31:0]     quoa_reg [0:ST];
    logic [31:0]     quob_reg [0:ST];
    pgng_pkg::root_t rc_reg   [0:ST];

    for (genvar k = 0; k <= ST; k++) begin : g_phase_c
        logic            v_next, na_next, nb_next;
        logic [31:0]     q_next, rema_next, remb_next, loa_next, lob_next;
        logic [31:0]     quoa_next, quob_next;
        pgng_pkg::root_t r_next;
        if (k == 0) begin : g_head
            always_comb begin
                v_next    = vb_reg;
                na_next   = nab_reg;
                nb_next   = nbb_reg;
                q_next    = qb_reg;
                rema_next = numa_next[63:32];
                remb_next = numb_next[63:32];
                loa_next  = numa_next[31:0];
                lob_next  = numb_next[31:0];
                quoa_next = '0;
                quob_next = '0;
                r_next.n  = wc_next;
                r_next.r  = '0;
            end
        end else begin : g_step
            logic [32:0] ta, tb;
            logic        gea, geb;
            always_comb begin
                ta        = {rema_reg[k-1], loa_reg[k-1][31]};
                tb        = {remb_reg[k-1], lob2_reg[k-1][31]};
                gea       = ta >= {1'b0, qc_reg[k-1]};
                geb       = tb >= {1'b0, qc_reg[k-1]};
                v_next    = vc_reg[k-1];
                na_next   = nac_reg[k-1];
                nb_next   = nbc_reg[k-1];
                q_next    = qc_reg[k-1];
                rema_next = gea ? 32'(ta - {1'b0, qc_reg[k-1]}) : ta[31:0];
                remb_next = geb ? 32'(tb - {1'b0, qc_reg[k-1]}) : tb[31:0];
                loa_next  = loa_reg[k-1] << 1;
                lob_next  = lob2_reg[k-1] << 1;
                quoa_next = {quoa_reg[k-1][30:0], gea};
                quob_next = {quob_reg[k-1][30:0], geb};
                r_next    = pgng_pkg::root_step(rc_reg[k-1],
                                                64'(1) << (62 - 2 * (k - 1)));
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vc_reg[k] <= 1'b0;
            end else if (adv) begin
                vc_reg[k] <= v_next;
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                nac_reg[k]  <= na_next;
                nbc_reg[k]  <= nb_next;
                qc_reg[k]   <= q_next;
                rema_reg[k] <= rema_next;
                remb_reg[k] <= remb_next;
                loa_reg[k]  <= loa_next;
                lob2_reg[k] <= lob_next;
                quoa_reg[k] <= quoa_next;
                quob_reg[k] <= quob_next;
                rc_reg[k]   <= r_next;
            end
        end
    end

    // phase d, stage 1: ratio times root, q.19 after the shift
    logic        vd1_reg, nad1_reg, nbd1_reg;
    logic [63:0] gad1_reg, gbd1_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd1_reg <= 1'b0;
        end else if (adv) begin
            vd1_reg <= vc_reg[ST];
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            nad1_reg <= nac_reg[ST];
            nbd1_reg <= nbc_reg[ST];
            gad1_reg <= 64'(quoa_reg[ST]) * 64'(rc_reg[ST].r[31:0]);
            gbd1_reg <= 64'(quob_reg[ST]) * 64'(rc_reg[ST].r[31:0]);
        end
    end

    // phase d, stage 2: gain
    logic [48:0] pa_next, pb_next;
    logic        vd2_reg, nad2_reg, nbd2_reg;
    logic [33:0] mad2_reg, mbd2_reg;
    assign pa_next = 49'(gad1_reg[63:31]) * 49'(gain_reg);
    assign pb_next = 49'(gbd1_reg[63:31]) * 49'(gain_reg);
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd2_reg <= 1'b0;
        end else if (adv) begin
            vd2_reg <= vd1_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            nad2_reg <= nad1_reg;
            nbd2_reg <= nbd1_reg;
            mad2_reg <= pa_next[48:15];
            mbd2_reg <= pb_next[48:15];
        end
    end

    // phase d, stage 3: saturate and apply sign
    logic [33:0] sata, satb;
    logic [pgng_pkg::SAMPLE_W-1:0] sa_next, sb_next;
    logic        vd3_reg;
    logic [pgng_pkg::SAMPLE_W-1:0] sad3_reg, sbd3_reg;
    always_comb begin
        if (nad2_reg) begin
            sata    = (mad2_reg > pgng_pkg::SAMPLE_MIN_MAG) ? pgng_pkg::SAMPLE_MIN_MAG
                                                            : mad2_reg;
            sa_next = pgng_pkg::SAMPLE_W'(34'd0 - sata);
        end else begin
            sata    = (mad2_reg > pgng_pkg::SAMPLE_MAX) ? pgng_pkg::SAMPLE_MAX : mad2_reg;
            sa_next = pgng_pkg::SAMPLE_W'(sata);
        end
        if (nbd2_reg) begin
            satb    = (mbd2_reg > pgng_pkg::SAMPLE_MIN_MAG) ? pgng_pkg::SAMPLE_MIN_MAG
                                                            : mbd2_reg;
            sb_next = pgng_pkg::SAMPLE_W'(34'd0 - satb);
        end else begin
            satb    = (mbd2_reg > pgng_pkg::SAMPLE_MAX) ? pgng_pkg::SAMPLE_MAX : mbd2_reg;
            sb_next = pgng_pkg::SAMPLE_W'(satb);
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd3_reg <= 1'b0;
        end else if (adv) begin
            vd3_reg <= vd2_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            sad3_reg <= sa_next;
            sbd3_reg <= sb_next;
        end
    end

    // output pair register: first sample, then second marked last
    logic pair_valid_reg, phase_reg, pair_free;
    logic [pgng_pkg::SAMPLE_W-1:0] pa_reg, pb_reg;

    assign pair_free = !pair_valid_reg || (phase_reg && m_ready);
    assign adv       = pair_free || !vd3_reg;
    assign s_ready   = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
        end else if (pair_free && vd3_reg) begin
            // a new pair replaces the one just finished
            pair_valid_reg <= 1'b1;
            phase_reg      <= 1'b0;
        end else if (pair_valid_reg && m_ready) begin
            if (!phase_reg) begin
                phase_reg <= 1'b1;
            end else begin
                phase_reg      <= 1'b0;
                pair_valid_reg <= 1'b0;
            end
        end
    end
    always_ff @(posedge aclk) begin
        if (pair_free && vd3_reg) begin
            pa_reg <= sad3_reg;
            pb_reg <= sbd3_reg;
        end
    end

    assign m_valid        = pair_valid_reg;
    assign m_noise_sample = phase_reg ? pb_reg : pa_reg;
    assign m_last         = phase_reg;

endmodule

>>> tb/testbench.sv
module testbench;

    localparam int UB = 24;
    localparam logic [63:0] HALF = 64'd1 << (UB - 1);
    localparam int LATENCY = 80;
    localparam int WATCHDOG_LIMIT = 20000;

    // expected noise sample with its last flag
    typedef struct {
        logic signed [pgng_pkg::SAMPLE_W-1:0] sample;
        logic                                 last;
    } noise_pair_t;

    // bitwise integer square root
    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // scale and saturate one magnitude
    function automatic logic [pgng_pkg::SAMPLE_W-1:0] scale_sample(logic [63:0] mag,
            logic neg, logic [63:0] q, int j, logic [63:0] r, logic [15:0] gain);
        logic [63:0] rho;
        logic [63:0] g;
        logic [63:0] m;
        rho = ((mag << j) << 30) / q;
        g = (rho * r) >> 31;
        m = (g * gain) >> 15;
        if (neg) begin
            if (m > 64'd4194304) m = 64'd4194304;
            m = 64'd0 - m;
        end else if (m > 64'd4194303) begin
            m = 64'd4194303;
        end
        return m[pgng_pkg::SAMPLE_W-1:0];
    endfunction

    class noise_scoreboard;
        noise_pair_t pending_samples[$];
        logic [15:0] gain;
        int          errors;
        int          trials;
        int          rejected;
        int          samples_seen;

        // note an accepted trial and queue its two samples if it passes
        function void note_trial(logic [UB-1:0] a, logic [UB-1:0] b);
            logic        na, nb;
            logic [63:0] da, db, s, f, frac, t, w, r, q;
            int          e, j;
            noise_pair_t p;
            trials++;
            na = a < HALF;
            nb = b < HALF;
            da = na ? HALF - a : a - HALF;
            db = nb ? HALF - b : b - HALF;
            s = da * da + db * db;
            if (s == 0 || s >= (64'd1 << (2 * UB - 2))) begin
                rejected++;
                return;
            end
            e = 0;
            for (int i = 0; i < 64; i++) if (s[i]) e = i;
            f = (e >= 31) ? s >> (e - 31) : s << (31 - e);
            frac = 0;
            for (int k = 0; k < 32; k++) begin
                f = (f * f) >> 31;
                frac = frac << 1;
                if (f >= (64'd1 << 32)) begin
                    f = f >> 1;
                    frac = frac | 1;
                end
            end
            t = (64'(2 * UB - 2 - e) << 32) - frac;
            w = 2 * ((((t >> 32) * 64'(pgng_pkg::LN2_Q32)) << 8)
                + (((t & 64'hFFFF_FFFF) * 64'(pgng_pkg::LN2_Q32)) >> 24));
            r = int_sqrt(w);
            j = (61 - e) / 2;
            q = int_sqrt(s << (2 * j));
            p.sample = scale_sample(da, na, q, j, r, gain);
            p.last = 1'b0;
            pending_samples.push_back(p);
            p.sample = scale_sample(db, nb, q, j, r, gain);
            p.last = 1'b1;
            pending_samples.push_back(p);
        endfunction

        function void check_sample(logic signed [pgng_pkg::SAMPLE_W-1:0] sample, logic last);
            noise_pair_t p;
            samples_seen++;
            if (pending_samples.size() == 0) begin
                $display("%0t: unexpected sample %0d last %0b", $time, sample, last);
                errors++;
                return;
            end
            p = pending_samples.pop_front();
            if (p.sample !== sample) begin
                $display("%0t: sample expected %0d actual %0d", $time, p.sample, sample);
                errors++;
            end
            if (p.last !== last) begin
                $display("%0t: last expected %0b actual %0b", $time, p.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                                 aclk = 0;
    logic                                 aresetn = 0;
    logic                                 cfg_valid = 0;
    logic                                 cfg_ready;
    logic [pgng_pkg::GAIN_W-1:0]          cfg_data = '0;
    logic                                 s_valid = 0;
    logic                                 s_ready;
    logic [UB-1:0]                        s_uniform_a = '0;
    logic [UB-1:0]                        s_uniform_b = '0;
    logic                                 m_valid;
    logic                                 m_ready = 0;
    logic signed [pgng_pkg::SAMPLE_W-1:0] m_noise_sample;
    logic                                 m_last;

    noise_scoreboard board = new();
    bit  stim_done = 0;
    bit  calm = 0;       // no idling on either side
    bit  hold_off = 0;   // receiver held for a long stretch
    int  idle_cycles = 0;

    always #10 aclk = ~aclk;

    polar_gaussian_noise_generator_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_uniform_a(s_uniform_a), .s_uniform_b(s_uniform_b),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_noise_sample(m_noise_sample), .m_last(m_last)
    );

    // scoreboard hooks at the edge, before drivers change anything
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.note_trial(s_uniform_a, s_uniform_b);
            if (m_valid && m_ready) board.check_sample(m_noise_sample, m_last);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog on cycles without any request
    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired at %0t", $time);
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random stalls unless calm or held off
    always @(posedge aclk) begin
        if (!aresetn || hold_off)
            m_ready <= 1'b0;
        else
            m_ready <= calm || ($urandom_range(99) >= 24);
    end

    // write noise_gain, only while idle
    task automatic write_gain(logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        board.gain = value;
    endtask

    // present one trial and wait until it is taken
    task automatic send_trial(logic [UB-1:0] a, logic [UB-1:0] b);
        while (!calm && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_uniform_a <= a;
        s_uniform_b <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic finish_sending();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // drain expected samples, then let a rejected trial leave the pipeline
    task automatic drain();
        while (board.pending_samples.size() != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    // random trial, mostly inside the unit circle
    task automatic random_trial();
        logic [UB-1:0] a, b;
        int            mode;
        mode = $urandom_range(9);
        if (mode < 7) begin
            // inner square of side 1.4 lies inside the circle
            a = UB'(HALF + 64'($urandom_range(2 * 5872025)) - 64'd5872025);
            b = UB'(HALF + 64'($urandom_range(2 * 5872025)) - 64'd5872025);
        end else if (mode == 7) begin
            // near center, small s and large magnitudes
            a = UB'(HALF + 64'($urandom_range(64)) - 64'd32);
            b = UB'(HALF + 64'($urandom_range(64)) - 64'd32);
        end else begin
            a = UB'($urandom);
            b = UB'($urandom);
        end
        send_trial(a, b);
    endtask

    logic [15:0] gains[4] = '{16'd32768, 16'd0, 16'd65535, 16'd0};

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_gain(16'd32768);
        // directed: corners, center, rejects, saturation, all sign combinations
        send_trial(24'h800000, 24'h800000);            // s == 0, rejected
        send_trial(24'h000000, 24'h800000);            // s == 1, rejected
        send_trial(24'h000000, 24'h000000);            // beyond circle
        send_trial(24'hFFFFFF, 24'hFFFFFF);            // beyond circle
        send_trial(24'h800001, 24'h800000);            // smallest s, saturates
        send_trial(24'h7FFFFF, 24'h800000);            // negative saturation
        send_trial(24'h800000, 24'h7FFFFF);
        send_trial(24'h000001, 24'h800000);            // just inside, -u
        send_trial(24'hFFFFFF, 24'h800000);            // just inside, +u
        send_trial(24'h800000, 24'h000001);
        send_trial(24'hC00000, 24'hC00000);
        send_trial(24'h400000, 24'hC00000);
        send_trial(24'hC00000, 24'h400000);
        send_trial(24'h400000, 24'h400000);
        send_trial(24'h555555, 24'hAAAAAA);
        send_trial(24'hAAAAAA, 24'h555555);
        send_trial(24'h8000FF, 24'h7FFF00);
        finish_sending();
        drain();

        // random phases across gains; the first one runs calm for a stretch
        for (int ph = 0; ph < 4; ph++) begin
            write_gain(ph == 3 ? 16'(1 + $urandom_range(32767)) : gains[ph]);
            calm = (ph == 0);
            for (int i = 0; i < 130; i++) begin
                random_trial();
                if (ph == 0 && i == 65) calm = 0;
            end
            finish_sending();
            drain();
        end

        // long receiver hold-off while trials keep coming
        write_gain(16'd16384);
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge aclk);
                hold_off = 0;
            end
            for (int i = 0; i < 120; i++) random_trial();
        join
        finish_sending();
        drain();
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        $display("%0d trials (%0d rejected), %0d samples checked, gains 0..65535",
                 board.trials, board.rejected, board.samples_seen);
        if (board.errors == 0 && board.pending_samples.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

>>> filelist.f
rtl/pgng_pkg.sv
rtl/polar_gaussian_noise_generator_core.sv
tb/testbench.sv
